// File: hw/rtl/dke_pkg.sv
package dke_pkg;

   // number format
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int VAR_W     = DATA_W - 1;
   localparam int NUM_COMP  = 4;
   localparam int COMP_W    = $clog2(NUM_COMP);

   // gain and divider sizes
   localparam int Q_W     = FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(Q_W + 1);
   localparam int DEN_W   = VAR_W + 1;
   localparam int NUM_W   = VAR_W + FRAC_BITS + 1;

   // datapath sizes
   localparam int DIFF_W  = DATA_W + 1;
   localparam int PRODC_W = Q_W + 1 + DIFF_W;
   localparam int PRODV_W = Q_W + VAR_W;
   localparam int SAT_W   = DIFF_W + 4;

   // constants
   localparam logic [VAR_W-1:0] ONE_Q = VAR_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0]   ONE_K = Q_W'(1) << FRAC_BITS;
   localparam logic [VAR_W-1:0] EPS_Q = VAR_W'(((1 << FRAC_BITS) + 5) / 10);

   // register map
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_EST_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VAR_BASE = CSR_IDX_W'(NUM_COMP);
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT         = CSR_IDX_W'(2 * NUM_COMP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DLOAD,
      ST_DIV,
      ST_MUL,
      ST_UPD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              predict;
      logic              div_start;
      logic              div_step;
      logic              mul;
      logic              update;
      logic              out_load;
      logic [COMP_W-1:0] comp;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   // clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
      logic all_same;
      logic signed [DATA_W-1:0] r;
      all_same = (v[SAT_W-1:DATA_W-1] == {(SAT_W-DATA_W+1){v[SAT_W-1]}});
      if (all_same) begin
         r = v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   // clamp a nonnegative value to the variance range
   function automatic logic [VAR_W-1:0] sat_var(input logic [VAR_W+1:0] v);
      logic [VAR_W-1:0] r;
      if (|v[VAR_W+1:VAR_W]) begin
         r = {VAR_W{1'b1}};
      end else begin
         r = v[VAR_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/dke_if.sv
interface dke_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [dke_pkg::DATA_W-1:0]    meas_0;
   logic signed [dke_pkg::DATA_W-1:0]    meas_1;
   logic signed [dke_pkg::DATA_W-1:0]    meas_2;
   logic signed [dke_pkg::DATA_W-1:0]    meas_3;
   modport source (output valid, meas_0, meas_1, meas_2, meas_3, input ready);
   modport sink   (input valid, meas_0, meas_1, meas_2, meas_3, output ready);
endinterface

interface dke_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [dke_pkg::DATA_W-1:0]    out_est_0;
   logic signed [dke_pkg::DATA_W-1:0]    out_est_1;
   modport source (output valid, out_est_0, out_est_1, input ready);
   modport sink   (input valid, out_est_0, out_est_1, output ready);
endinterface

interface dke_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dke_pkg::CSR_IDX_W-1:0]        addr;
   logic [dke_pkg::DATA_W-1:0]           data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/diagonal_kalman_estimator_4.sv
// four-component kalman estimator with diagonal covariance, signed fixed point
// req_ch: one item is a measurement meas_0..meas_3, taken when valid and ready are high
// rsp_ch: one item per measurement, the updated estimates out_est_0 and out_est_1
// csr_ch: writes the initial estimate (addr 0..3) and variance (addr 4..7); before the
//   first item a write lands directly in the running state, later it has no effect;
//   addresses past 7 are ignored; always ready, write only while the block is idle
// one item is worked at a time: a prediction step, then for each component a divider
//   load, a restoring division for the gain (one quotient bit a cycle), a multiply
//   and an update, then the result is loaded into the output register
// the gain divider is shared by all four components, so they are worked in turn
// the result sits in an output register, so a new item is accepted while it waits;
//   if the receiver still stalls when the next result is done, the block holds it
//   back until the register frees
// reset clears the state to zero estimates and variances and the first-step flag
module diagonal_kalman_estimator_4 (
   input  logic      clock,
   input  logic      reset,
   dke_req_if.sink   req_ch,
   dke_rsp_if.source rsp_ch,
   dke_csr_if.sink   csr_ch
);
   import dke_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_valid;

   // config writes never stall
   assign csr_ch.ready = 1'b1;

   dke_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dke_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_ch.valid),
      .csr_addr  (csr_ch.addr),
      .csr_data  (csr_ch.data),
      .meas_0    (req_ch.meas_0),
      .meas_1    (req_ch.meas_1),
      .meas_2    (req_ch.meas_2),
      .meas_3    (req_ch.meas_3),
      .out_est_0 (rsp_ch.out_est_0),
      .out_est_1 (rsp_ch.out_est_1)
   );

   assign rsp_ch.valid = rsp_valid;

   // at most one datapath command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.predict, cmd.div_start, cmd.div_step,
                cmd.mul, cmd.update, cmd.out_load}))
      else $error("more than one datapath command");

   // an accepted item starts the prediction next cycle and blocks new items
   a_accept_predict: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (cmd.predict && !req_ch.ready))
      else $error("accepted item not followed by prediction");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ch.ready))
      else $error("result overwritten while stalled");

   // the divider only steps between a start and its last bit
   a_div_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(cmd.div_step) |-> $past(cmd.div_start))
      else $error("divider stepped without a start");

endmodule

// File: hw/rtl/dke_ctrl.sv
module dke_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dke_pkg::stat_type stat,
   output dke_pkg::cmd_type  cmd
);
   import dke_pkg::*;

   state_type          state_ff, state_in;
   logic [COMP_W-1:0]  comp_ff, comp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               comp_last;
   logic               out_free;

   assign comp_last = (comp_ff == COMP_W'(NUM_COMP - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_PRED;
         ST_PRED:  state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV:   if (stat.div_last) state_in = ST_MUL;
         ST_MUL:   state_in = ST_UPD;
         ST_UPD:   state_in = comp_last ? ST_OUT : ST_DLOAD;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.comp      = comp_ff;
      comp_in       = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PRED: begin
            cmd.predict = 1'b1;
            comp_in     = '0;
         end
         ST_DLOAD: cmd.div_start = 1'b1;
         ST_DIV:   cmd.div_step  = 1'b1;
         ST_MUL:   cmd.mul       = 1'b1;
         ST_UPD: begin
            cmd.update = 1'b1;
            if (!comp_last) comp_in = comp_ff + COMP_W'(1);
         end
         ST_OUT:  cmd.out_load = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/dke_datapath.sv
module dke_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dke_pkg::cmd_type                     cmd,
   output dke_pkg::stat_type                    stat,
   input  logic                                 csr_we,
   input  logic [dke_pkg::CSR_IDX_W-1:0]        csr_addr,
   input  logic [dke_pkg::DATA_W-1:0]           csr_data,
   input  logic signed [dke_pkg::DATA_W-1:0]    meas_0,
   input  logic signed [dke_pkg::DATA_W-1:0]    meas_1,
   input  logic signed [dke_pkg::DATA_W-1:0]    meas_2,
   input  logic signed [dke_pkg::DATA_W-1:0]    meas_3,
   output logic signed [dke_pkg::DATA_W-1:0]    out_est_0,
   output logic signed [dke_pkg::DATA_W-1:0]    out_est_1
);
   import dke_pkg::*;

   localparam logic [PRODC_W-1:0] HALF_C = PRODC_W'(1) << (FRAC_BITS - 1);
   localparam logic [PRODV_W-1:0] HALF_V = PRODV_W'(1) << (FRAC_BITS - 1);

   // running state
   logic signed [DATA_W-1:0] est_ff [NUM_COMP];
   logic signed [DATA_W-1:0] est_in [NUM_COMP];
   logic [VAR_W-1:0]         var_ff [NUM_COMP];
   logic [VAR_W-1:0]         var_in [NUM_COMP];
   logic                     seen_ff, seen_in;

   // per-item working registers
   logic signed [DATA_W-1:0] z_ff  [NUM_COMP];
   logic signed [DATA_W-1:0] z_in  [NUM_COMP];
   logic signed [DATA_W-1:0] p_ff  [NUM_COMP];
   logic signed [DATA_W-1:0] p_in  [NUM_COMP];
   logic [VAR_W-1:0]         pc_ff [NUM_COMP];
   logic [VAR_W-1:0]         pc_in [NUM_COMP];

   // divider
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           qsh_ff, qsh_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   // products
   logic signed [PRODC_W-1:0] prodc_ff, prodc_in;
   logic [PRODV_W-1:0]        prodv_ff, prodv_in;

   logic signed [DATA_W-1:0]  out0_ff, out0_in, out1_ff, out1_in;

   // selected component
   logic signed [DATA_W-1:0]  z_sel, p_sel;
   logic [VAR_W-1:0]          pc_sel;

   assign z_sel  = z_ff[cmd.comp];
   assign p_sel  = p_ff[cmd.comp];
   assign pc_sel = pc_ff[cmd.comp];

   // prediction and predicted variance
   always_comb begin
      logic signed [SAT_W-1:0] e0, e1, e2, e3;
      logic signed [SAT_W-1:0] h0, h1, h01;
      logic [VAR_W:0]          vsum;
      logic [VAR_W-1:0]        d [NUM_COMP];
      e0   = SAT_W'(est_ff[0]);
      e1   = SAT_W'(est_ff[1]);
      e2   = SAT_W'(est_ff[2]);
      e3   = SAT_W'(est_ff[3]);
      h0   = $signed(SAT_W'(var_ff[0][VAR_W-1:1]));
      h1   = $signed(SAT_W'(var_ff[1][VAR_W-1:1]));
      vsum = (VAR_W+1)'(var_ff[0]) + (VAR_W+1)'(var_ff[1]);
      h01  = $signed(SAT_W'(vsum[VAR_W:1]));
      p_in  = p_ff;
      pc_in = pc_ff;
      for (int i = 0; i < NUM_COMP; i++) begin
         d[i] = seen_ff ? sat_var((VAR_W+2)'(var_ff[i]) + (VAR_W+2)'(ONE_Q)) : ONE_Q;
      end
      if (cmd.predict) begin
         p_in[0]  = sat_s32(e0 + h0);
         p_in[1]  = sat_s32(e1 + h1);
         p_in[2]  = sat_s32(e2 + e0 + h01);
         p_in[3]  = sat_s32(e3 + e1);
         pc_in[0] = d[0];
         pc_in[1] = d[1];
         pc_in[2] = sat_var((VAR_W+2)'(d[2]) + (VAR_W+2)'(d[0]));
         pc_in[3] = sat_var((VAR_W+2)'(d[3]) + (VAR_W+2)'(d[1]));
      end
   end

   // gain divider, one quotient bit a cycle
   always_comb begin
      logic [DEN_W-1:0] den_new;
      logic [NUM_W-1:0] num;
      logic [DEN_W:0]   trial;
      logic             ge;
      den_new = DEN_W'(pc_sel) + DEN_W'(EPS_Q);
      num     = (NUM_W'(pc_sel) << FRAC_BITS) + NUM_W'(den_new >> 1);
      trial   = {rem_ff, qsh_ff[Q_W-1]};
      ge      = (trial >= (DEN_W+1)'(den_ff));
      den_in  = den_ff;
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      cnt_in  = cnt_ff;
      if (cmd.div_start) begin
         den_in = den_new;
         rem_in = DEN_W'(num[NUM_W-1:Q_W]);
         qsh_in = num[Q_W-1:0];
         cnt_in = CNT_W'(Q_W);
      end else if (cmd.div_step) begin
         rem_in = ge ? DEN_W'(trial - (DEN_W+1)'(den_ff)) : DEN_W'(trial);
         qsh_in = {qsh_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign stat.div_last = (cnt_ff == CNT_W'(1));

   // correction and variance products
   always_comb begin
      logic signed [DIFF_W-1:0] diff;
      logic [Q_W-1:0]           one_minus_k;
      diff        = DIFF_W'(z_sel) - DIFF_W'(p_sel);
      one_minus_k = ONE_K - qsh_ff;
      prodc_in    = prodc_ff;
      prodv_in    = prodv_ff;
      if (cmd.mul) begin
         prodc_in = PRODC_W'($signed({1'b0, qsh_ff})) * PRODC_W'(diff);
         prodv_in = PRODV_W'(one_minus_k) * PRODV_W'(pc_sel);
      end
   end

   // state update, input latch and register writes
   always_comb begin
      logic [PRODC_W-1:0]          mag;
      logic [PRODC_W-FRAC_BITS-1:0] q;
      logic signed [SAT_W-1:0]     qext, corr;
      logic [PRODV_W-1:0]          vsum;
      logic [COMP_W-1:0]           widx;
      mag   = prodc_ff[PRODC_W-1] ? PRODC_W'(-prodc_ff) : PRODC_W'(prodc_ff);
      q     = (PRODC_W-FRAC_BITS)'((mag + HALF_C) >> FRAC_BITS);
      qext  = $signed(SAT_W'(q));
      corr  = prodc_ff[PRODC_W-1] ? -qext : qext;
      vsum  = prodv_ff + HALF_V;
      widx  = '0;
      est_in  = est_ff;
      var_in  = var_ff;
      seen_in = seen_ff;
      z_in    = z_ff;
      if (cmd.load) begin
         z_in[0] = meas_0;
         z_in[1] = meas_1;
         z_in[2] = meas_2;
         z_in[3] = meas_3;
      end
      if (cmd.update) begin
         est_in[cmd.comp] = sat_s32(SAT_W'(p_sel) + corr);
         var_in[cmd.comp] = sat_var((VAR_W+2)'(vsum[PRODV_W-1:FRAC_BITS]));
         if (cmd.comp == COMP_W'(NUM_COMP - 1)) seen_in = 1'b1;
      end else if (csr_we && !seen_ff) begin
         // initial values go straight into the state until the first item
         if (csr_addr < CSR_INIT_VAR_BASE) begin
            widx = COMP_W'(csr_addr - CSR_INIT_EST_BASE);
            est_in[widx] = $signed(csr_data);
         end else if (csr_addr < CSR_COUNT) begin
            widx = COMP_W'(csr_addr - CSR_INIT_VAR_BASE);
            var_in[widx] = csr_data[VAR_W-1:0];
         end
      end
   end

   always_comb begin
      out0_in = out0_ff;
      out1_in = out1_ff;
      if (cmd.out_load) begin
         out0_in = est_ff[0];
         out1_in = est_ff[1];
      end
   end

   assign out_est_0 = out0_ff;
   assign out_est_1 = out1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff  <= '{default: '0};
         var_ff  <= '{default: '0};
         seen_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         est_ff  <= est_in;
         var_ff  <= var_in;
         seen_ff <= seen_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff     <= z_in;
      p_ff     <= p_in;
      pc_ff    <= pc_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      qsh_ff   <= qsh_in;
      prodc_ff <= prodc_in;
      prodv_ff <= prodv_in;
      out0_ff  <= out0_in;
      out1_ff  <= out1_in;
   end

endmodule

// File: sim/diagonal_kalman_estimator_4_test.sv
module diagonal_kalman_estimator_4_test;

   localparam int     NC        = dke_pkg::NUM_COMP;
   localparam int     IDX_W     = dke_pkg::CSR_IDX_W;
   localparam int     FRAC      = dke_pkg::FRAC_BITS;
   localparam longint ONE_V     = longint'(1) << FRAC;
   localparam longint HALF_V    = ONE_V / 2;
   localparam longint EPS_V     = (ONE_V + 5) / 10;
   localparam longint S32_MAX_V = 64'sd2147483647;
   localparam longint S32_MIN_V = -64'sd2147483648;
   localparam int     STALL_LIMIT = 5000;
   localparam int     HOLD_AFTER  = 40;
   localparam int     HOLD_LEN    = 700;
   localparam int     IDLE_PCT    = 36;

   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef logic [IDX_W-1:0] reg_idx_t;
   localparam reg_idx_t IDX_TOP = '1;

   typedef struct packed {
      logic signed [31:0] meas_0;
      logic signed [31:0] meas_1;
      logic signed [31:0] meas_2;
      logic signed [31:0] meas_3;
   } meas_t;

   typedef struct packed {
      logic signed [31:0] est_0;
      logic signed [31:0] est_1;
   } est_pair_t;

   // register value patterns used across the configuration phases
   typedef enum {CFG_EDGE, CFG_HIGH, CFG_LOW, CFG_RAND} cfg_style_t;

   // tracks the filter state, predicts each estimate pair and checks the results
   class est_tracker;
      longint    reg_est[NC];
      longint    reg_cov[NC];
      longint    est[NC];
      longint    cov[NC];
      bit        stepped;
      est_pair_t est_due[$];
      int        mismatch_cnt;

      function longint clamp_s32(longint v);
         return (v > S32_MAX_V) ? S32_MAX_V : ((v < S32_MIN_V) ? S32_MIN_V : v);
      endfunction

      function longint clamp_var(longint v);
         return (v > S32_MAX_V) ? S32_MAX_V : ((v < 0) ? 0 : v);
      endfunction

      function void note_reg(reg_idx_t idx, logic [31:0] value);
         int j;
         if (idx < dke_pkg::CSR_INIT_VAR_BASE) begin
            j = idx - dke_pkg::CSR_INIT_EST_BASE;
            reg_est[j] = longint'(signed'(value));
            if (!stepped) est[j] = reg_est[j];
         end else if (idx < dke_pkg::CSR_COUNT) begin
            j = idx - dke_pkg::CSR_INIT_VAR_BASE;
            reg_cov[j] = longint'(value[30:0]);
            if (!stepped) cov[j] = reg_cov[j];
         end
      endfunction

      // one filter step: predict, form the gain, update estimate and variance
      function void note_meas(meas_t m);
         longint z[NC], p[NC], d[NC], pc[NC];
         longint k, den, num, diff, mag, corr, cv;
         est_pair_t res;
         int i;
         z[0] = m.meas_0;
         z[1] = m.meas_1;
         z[2] = m.meas_2;
         z[3] = m.meas_3;
         p[0] = clamp_s32(est[0] + (cov[0] >>> 1));
         p[1] = clamp_s32(est[1] + (cov[1] >>> 1));
         p[2] = clamp_s32(est[2] + est[0] + ((cov[0] + cov[1]) >>> 1));
         p[3] = clamp_s32(est[3] + est[1]);
         for (i = 0; i < NC; i++) d[i] = stepped ? clamp_var(cov[i] + ONE_V) : ONE_V;
         pc[0] = d[0];
         pc[1] = d[1];
         pc[2] = clamp_var(d[2] + d[0]);
         pc[3] = clamp_var(d[3] + d[1]);
         for (i = 0; i < NC; i++) begin
            den  = pc[i] + EPS_V;
            num  = pc[i] << FRAC;
            k    = (num + den / 2) / den;
            diff = z[i] - p[i];
            mag  = k * diff;
            corr = (mag < 0) ? -((-mag + HALF_V) >>> FRAC) : ((mag + HALF_V) >>> FRAC);
            cv   = ((ONE_V - k) * pc[i] + HALF_V) >>> FRAC;
            est[i] = clamp_s32(p[i] + corr);
            cov[i] = clamp_var(cv);
         end
         stepped = 1'b1;
         res.est_0 = 32'(est[0]);
         res.est_1 = 32'(est[1]);
         est_due.push_back(res);
      endfunction

      function void flag(string msg);
         mismatch_cnt++;
         if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_est(logic signed [31:0] got_0, logic signed [31:0] got_1);
         est_pair_t want;
         if (est_due.size() == 0) begin
            flag($sformatf("result %0d %0d with nothing expected", got_0, got_1));
         end else begin
            want = est_due.pop_front();
            if (got_0 !== want.est_0)
               flag($sformatf("out_est_0 expected %0d got %0d", want.est_0, got_0));
            if (got_1 !== want.est_1)
               flag($sformatf("out_est_1 expected %0d got %0d", want.est_1, got_1));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;   // no idling on either side while set
   int   quiet_cycles;
   est_tracker book;

   dke_req_if req_ch ();
   dke_rsp_if rsp_ch ();
   dke_csr_if csr_ch ();

   diagonal_kalman_estimator_4 u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // offer one measurement, with a random gap before it; valid stays high after
   // the accept so a following item can go out without a bubble
   task automatic send_meas(input meas_t m);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.meas_0 <= m.meas_0;
      req_ch.meas_1 <= m.meas_1;
      req_ch.meas_2 <= m.meas_2;
      req_ch.meas_3 <= m.meas_3;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book.note_meas(m);
   endtask

   // one register write; the caller lowers valid after the last write
   task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      book.note_reg(idx, value);
   endtask

   // sender holds back until every result is in
   task automatic drain();
      while (book.est_due.size() != 0) @(posedge clock);
   endtask

   // write every register with one pattern, plus an overwrite and two
   // writes past the end of the register map
   task automatic program_all(input cfg_style_t style);
      logic [31:0] val;
      int i;
      write_reg(dke_pkg::CSR_INIT_EST_BASE, $urandom());
      for (i = 0; i < NC; i++) begin
         case (style)
            CFG_EDGE: val = i[0] ? Q_MIN : Q_MAX;
            CFG_HIGH: val = Q_MAX;
            CFG_LOW:  val = Q_MIN;
            default:  val = $urandom();
         endcase
         write_reg(reg_idx_t'(dke_pkg::CSR_INIT_EST_BASE + i), val);
      end
      for (i = 0; i < NC; i++) begin
         case (style)
            // bit 31 set on the first one, must be dropped by the 31-bit field
            CFG_EDGE: val = (i == 0) ? 32'hffffffff : (i == 1) ? 32'h7fffffff :
                            (i == 2) ? 32'h0 : $urandom();
            CFG_HIGH: val = 32'hffffffff;
            CFG_LOW:  val = 32'h0;
            default:  val = $urandom();
         endcase
         write_reg(reg_idx_t'(dke_pkg::CSR_INIT_VAR_BASE + i), val);
      end
      write_reg(dke_pkg::CSR_COUNT, $urandom());
      write_reg(IDX_TOP, $urandom());
      csr_ch.valid <= 1'b0;
   endtask

   // random measurements: mostly near the running estimate or small, with
   // full-range noise and extremes mixed in
   task automatic run_phase(input int count);
      logic signed [31:0] v[NC];
      meas_t m;
      int i, c;
      for (i = 0; i < count; i++) begin
         for (c = 0; c < NC; c++) begin
            case ($urandom_range(9))
               0, 1:    v[c] = $urandom();
               2:       v[c] = $urandom_range(1) ? Q_MAX : Q_MIN;
               3, 4, 5: v[c] = 32'(book.est[c] + longint'($urandom_range(8192)) - 4096);
               default: v[c] = $urandom_range(2097152) - 32'd1048576;
            endcase
         end
         m.meas_0 = v[0];
         m.meas_1 = v[1];
         m.meas_2 = v[2];
         m.meas_3 = v[3];
         send_meas(m);
      end
      req_ch.valid <= 1'b0;
   endtask

   // result side: random stalls, checks every accepted item, and one long
   // hold-off so the output register and the input side back up
   initial begin
      int taken;
      int hold_left;
      taken = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            book.check_est(rsp_ch.out_est_0, rsp_ch.out_est_1);
            taken++;
            if (taken == HOLD_AFTER) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog: ends the run when no channel moves an item for too long
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      book = new();
      calm = 1'b0;
      reset <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.meas_0 <= '0;
      req_ch.meas_1 <= '0;
      req_ch.meas_2 <= '0;
      req_ch.meas_3 <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.addr   <= '0;
      csr_ch.data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // before the first item the writes land in the running state:
      // saturating estimates and variances from zero up to the largest
      program_all(CFG_EDGE);

      // directed: first step saturates the prediction, then field extremes
      send_meas(meas_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      send_meas(meas_t'{Q_MAX, Q_MAX, Q_MAX, Q_MAX});
      send_meas(meas_t'{Q_MIN, Q_MIN, Q_MIN, Q_MIN});
      send_meas(meas_t'{Q_MAX, Q_MIN, Q_MAX, Q_MIN});
      send_meas(meas_t'{Q_MIN, Q_MAX, Q_MIN, Q_MAX});
      send_meas(meas_t'{Q_MAX, Q_MAX, Q_MIN, Q_MIN});
      send_meas(meas_t'{-32'sd1, -32'sd1, -32'sd1, -32'sd1});
      send_meas(meas_t'{32'sd1, 32'sd1, 32'sd1, 32'sd1});
      send_meas(meas_t'{32'sh00010000, -32'sh00010000, 32'sh00020000, -32'sh00020000});
      send_meas(meas_t'{32'sh7fff0000, 32'sh8000ffff, 32'sh0000ffff, 32'shffff0000});
      send_meas(meas_t'{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa});
      send_meas(meas_t'{32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555});
      send_meas(meas_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      send_meas(meas_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0});
      req_ch.valid <= 1'b0;

      // after the first step register writes must leave the filter alone
      drain();
      program_all(CFG_HIGH);
      run_phase(130);   // long result hold-off falls in here

      drain();
      program_all(CFG_RAND);
      calm = 1'b1;      // back-to-back stretch on both sides
      run_phase(90);
      calm = 1'b0;

      drain();
      program_all(CFG_LOW);
      run_phase(170);

      drain();
      repeat (100) @(posedge clock);
      if (book.mismatch_cnt == 0 && book.est_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
